FILE: sv/real_fft_in_place_macros.svh
// ----------------------------------------------------------------------------
// real_fft_in_place_macros
// assertion macros shared by the real fft block
// ----------------------------------------------------------------------------
`ifndef REAL_FFT_IN_PLACE_MACROS_SVH
`define REAL_FFT_IN_PLACE_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define RFFT_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked out of reset
`define RFFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RFFT_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define RFFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/rfft_pkg.sv
// ----------------------------------------------------------------------------
// rfft_pkg
// constants, types, twiddle table and helpers for the real fft block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfft_pkg;

    localparam int POINTS = 512;
    localparam int LOG2P  = $clog2(POINTS);
    localparam int LOGN   = LOG2P - 1;
    localparam int ADDR_W = LOG2P;
    localparam int QTR    = POINTS / 4;
    localparam int HALF   = POINTS / 2;
    localparam int STG_W  = (LOGN > 1) ? $clog2(LOGN) : 1;
    localparam int OPD_W  = 17;
    localparam int PRD_W  = 2 * OPD_W;
    localparam int ACC_W  = 40;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_READ = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_15,
        SH_16
    } shift_t;

    typedef struct packed {
        logic   en;
        logic   first;
        logic   sub;
        shift_t shift;
    } mac_ctl_t;

    typedef struct packed {
        logic              valid;
        mode_t             mode;
        logic [ADDR_W-1:0] addr;
        logic              addr_ok;
        logic [15:0]       sample;
    } cmd_t;

    typedef struct packed {
        logic signed [OPD_W-1:0] c;
        logic signed [OPD_W-1:0] s;
    } tw_t;

    typedef logic [15:0] tw_tab_t [0:QTR];

    // q1.15 sine from a q2.30 taylor series, rounded half up
    function automatic logic [15:0] sin_entry(input int j);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          r;
        x = (TWO_PI_Q30 * 64'(j) + 64'(POINTS / 2)) / 64'(POINTS);
        sum = longint'(x);
        term = x;
        for (int k = 1; k <= 12; k++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        r = (sum + 16384) >>> 15;
        if (r > 32767) r = 32767;
        return r[15:0];
    endfunction

    function automatic tw_tab_t build_tab();
        tw_tab_t tab;
        for (int j = 0; j <= QTR; j++) tab[j] = sin_entry(j);
        return tab;
    endfunction

    localparam tw_tab_t TW_TAB = build_tab();

    // cos and sin of 2*pi*idx/POINTS by quarter-wave symmetry
    function automatic tw_t twiddle(input logic [LOGN-1:0] idx);
        tw_t w;
        int  ii;
        ii = int'(idx);
        if (ii <= QTR) begin
            w.s = {1'b0, TW_TAB[ii]};
            w.c = {1'b0, TW_TAB[QTR - ii]};
        end else begin
            w.s = {1'b0, TW_TAB[HALF - ii]};
            w.c = -$signed({1'b0, TW_TAB[ii - QTR]});
        end
        return w;
    endfunction

    function automatic logic [LOGN-1:0] bitrev(input logic [LOGN-1:0] v);
        logic [LOGN-1:0] r;
        for (int b = 0; b < LOGN; b++) r[LOGN-1-b] = v[b];
        return r;
    endfunction

    // divide by 2^sh toward zero, then clamp to 16 bits
    function automatic logic signed [15:0] sat_shift(input logic signed [ACC_W-1:0] acc,
                                                    input shift_t sh);
        logic signed [ACC_W-1:0] bias;
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32767);
        lo = -ACC_W'(32768);
        case (sh)
            SH_15: begin
                bias = acc[ACC_W-1] ? ACC_W'(32767) : '0;
                t = (acc + bias) >>> 15;
            end
            SH_16: begin
                bias = acc[ACC_W-1] ? ACC_W'(65535) : '0;
                t = (acc + bias) >>> 16;
            end
            default: begin
                bias = '0;
                t = acc + bias;
            end
        endcase
        if (t > hi) return 16'sh7fff;
        else if (t < lo) return -16'sh8000;
        else return t[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/rfft_mac.sv
// ----------------------------------------------------------------------------
// rfft_mac
// shared multiply-accumulate unit with truncating, saturating output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfft_mac (
    input  wire logic                               aclk,
    input  wire rfft_pkg::mac_ctl_t                 ctl,
    input  wire logic signed [rfft_pkg::OPD_W-1:0]  opd_a,
    input  wire logic signed [rfft_pkg::OPD_W-1:0]  opd_b,
    input  wire logic signed [rfft_pkg::ACC_W-1:0]  base,
    output logic signed [15:0]                      result
);
    import rfft_pkg::*;

    logic signed [PRD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] start;
    logic signed [ACC_W-1:0] addend;

    always_comb begin
        start    = ctl.first ? base : acc_reg;
        addend   = ACC_W'(prod_reg);
        acc_next = ctl.sub ? start - addend : start + addend;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= opd_a * opd_b;
        if (ctl.en) begin
            acc_reg <= acc_next;
        end
    end

    assign result = sat_shift(acc_reg, ctl.shift);

endmodule

`default_nettype wire

FILE: sv/rfft_core.sv
// ----------------------------------------------------------------------------
// rfft_core
// sample buffer and butterfly sequencer around the shared mac
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfft_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire rfft_pkg::cmd_t  cmd,
    output logic [15:0]          rd_data,
    output logic                 busy,
    output logic                 done
);
    import rfft_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_CALC,
        ST_NEXT,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        PH_SWAP,
        PH_BFLY,
        PH_SPLIT,
        PH_DC
    } phase_t;

    state_t            state_reg;
    phase_t            phase_reg;
    logic [LOGN-1:0]   cnt_reg;
    logic [STG_W-1:0]  stg_reg;
    logic [2:0]        rcnt_reg;
    logic [1:0]        out_reg;
    logic [1:0]        t_reg;

    logic [ADDR_W-1:0]       addr_reg [4];
    logic signed [15:0]      v_reg [4];
    logic signed [OPD_W-1:0] c_reg;
    logic signed [OPD_W-1:0] s_reg;

    logic [15:0]       mem [0:POINTS-1];
    logic [15:0]       rd_data_reg;

    // setup decode
    logic [ADDR_W-1:0] set_addr [4];
    logic [LOGN-1:0]   pi_a;
    logic [LOGN-1:0]   pi_b;
    logic [LOGN-1:0]   kk;
    logic [LOGN-1:0]   h_mask;
    logic [LOGN-1:0]   tw_idx;
    logic              skip;
    tw_t               tw;
    int                amt;

    always_comb begin
        pi_a   = '0;
        pi_b   = '0;
        tw_idx = '0;
        skip   = 1'b0;
        h_mask = LOGN'((1 << stg_reg) - 1);
        kk     = LOGN'(cnt_reg[LOGN-2:0]) & h_mask;
        amt    = (LOGN - 1) - int'(stg_reg);
        for (int q = 0; q < 4; q++) set_addr[q] = '0;
        case (phase_reg)
            PH_SWAP: begin
                pi_a = cnt_reg;
                pi_b = bitrev(cnt_reg);
                skip = !(pi_b > pi_a);
            end
            PH_BFLY: begin
                pi_a   = (((LOGN'(cnt_reg[LOGN-2:0]) >> stg_reg) << stg_reg) << 1) | kk;
                pi_b   = pi_a | (LOGN'(1) << stg_reg);
                tw_idx = (kk << amt) << 1;
            end
            default: begin
                tw_idx = cnt_reg;
            end
        endcase
        case (phase_reg)
            PH_SPLIT: begin
                set_addr[0] = {cnt_reg, 1'b0};
                set_addr[1] = {cnt_reg, 1'b1};
                set_addr[2] = ADDR_W'(POINTS - 2 * int'(cnt_reg));
                set_addr[3] = ADDR_W'(POINTS - 2 * int'(cnt_reg) + 1);
            end
            PH_DC: begin
                set_addr[0] = ADDR_W'(0);
                set_addr[1] = ADDR_W'(1);
                set_addr[2] = ADDR_W'(0);
                set_addr[3] = ADDR_W'(1);
            end
            default: begin
                set_addr[0] = {pi_a, 1'b0};
                set_addr[1] = {pi_a, 1'b1};
                set_addr[2] = {pi_b, 1'b0};
                set_addr[3] = {pi_b, 1'b1};
            end
        endcase
        tw = twiddle(tw_idx);
    end

    // per-output operand and sign selection
    logic signed [OPD_W-1:0] s02;
    logic signed [OPD_W-1:0] d13;
    logic signed [OPD_W-1:0] h2r;
    logic signed [OPD_W-1:0] h2i;
    logic signed [ACC_W-1:0] base;
    logic signed [OPD_W-1:0] opd_a;
    logic signed [OPD_W-1:0] opd_b;
    logic                    neg1;
    logic                    neg2;
    mac_ctl_t                ctl;
    logic signed [15:0]      mac_result;

    always_comb begin
        s02   = OPD_W'(v_reg[0]) + OPD_W'(v_reg[2]);
        d13   = OPD_W'(v_reg[1]) - OPD_W'(v_reg[3]);
        h2r   = OPD_W'(v_reg[1]) + OPD_W'(v_reg[3]);
        h2i   = OPD_W'(v_reg[2]) - OPD_W'(v_reg[0]);
        opd_a = (t_reg == 2'd0) ? c_reg : s_reg;
        opd_b = '0;
        neg1  = 1'b0;
        neg2  = 1'b0;
        ctl.shift = SH_0;
        case (phase_reg)
            PH_SWAP: begin
                base = ACC_W'(v_reg[out_reg ^ 2'd2]);
            end
            PH_BFLY: begin
                base  = ACC_W'(v_reg[{1'b0, out_reg[0]}]) <<< 15;
                opd_b = (t_reg == 2'd0) ? OPD_W'(v_reg[{1'b1, out_reg[0]}])
                                        : OPD_W'(v_reg[{1'b1, ~out_reg[0]}]);
                neg1  = out_reg[1];
                neg2  = (out_reg == 2'd0) || (out_reg == 2'd3);
                ctl.shift = SH_15;
            end
            PH_SPLIT: begin
                case (out_reg)
                    2'd1:    base = ACC_W'(d13) <<< 15;
                    2'd3:    base = -(ACC_W'(d13) <<< 15);
                    default: base = ACC_W'(s02) <<< 15;
                endcase
                if (t_reg == 2'd0) opd_b = out_reg[0] ? h2i : h2r;
                else opd_b = out_reg[0] ? h2r : h2i;
                neg1  = (out_reg == 2'd2);
                neg2  = (out_reg == 2'd0);
                ctl.shift = SH_16;
            end
            default: begin
                base = out_reg[0] ? ACC_W'(v_reg[0]) - ACC_W'(v_reg[1])
                                  : ACC_W'(v_reg[0]) + ACC_W'(v_reg[1]);
            end
        endcase
        ctl.en    = (state_reg == ST_CALC) && ((t_reg == 2'd1) || (t_reg == 2'd2));
        ctl.first = (t_reg == 2'd1);
        ctl.sub   = (t_reg == 2'd1) ? neg1 : neg2;
    end

    rfft_mac u_mac (
        .aclk   (aclk),
        .ctl    (ctl),
        .opd_a  (opd_a),
        .opd_b  (opd_b),
        .base   (base),
        .result (mac_result)
    );

    // memory ports
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic              calc_we;

    always_comb begin
        calc_we = (state_reg == ST_CALC) && (t_reg == 2'd3)
                  && ((phase_reg != PH_DC) || !out_reg[1]);
        if (state_reg == ST_IDLE) begin
            mem_we    = cmd.valid && (cmd.mode == MODE_LOAD) && cmd.addr_ok;
            mem_waddr = cmd.addr;
            mem_wdata = cmd.sample;
            mem_raddr = cmd.addr;
        end else begin
            mem_we    = calc_we;
            mem_waddr = addr_reg[out_reg];
            mem_wdata = mac_result;
            mem_raddr = addr_reg[rcnt_reg[1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // operand capture
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SETUP) begin
            for (int q = 0; q < 4; q++) addr_reg[q] <= set_addr[q];
            if ((phase_reg == PH_BFLY) || (phase_reg == PH_SPLIT)) begin
                c_reg <= tw.c;
                s_reg <= tw.s;
            end else begin
                c_reg <= '0;
                s_reg <= '0;
            end
        end
        if ((state_reg == ST_READ) && (rcnt_reg != 3'd0)) begin
            v_reg[2'(rcnt_reg - 3'd1)] <= rd_data_reg;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_SWAP;
            cnt_reg   <= '0;
            stg_reg   <= '0;
            rcnt_reg  <= '0;
            out_reg   <= '0;
            t_reg     <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (cmd.valid && (cmd.mode == MODE_RUN)) begin
                        state_reg <= ST_SETUP;
                        phase_reg <= PH_SWAP;
                        cnt_reg   <= '0;
                        stg_reg   <= '0;
                    end
                end
                ST_SETUP: begin
                    rcnt_reg  <= '0;
                    state_reg <= skip ? ST_NEXT : ST_READ;
                end
                ST_READ: begin
                    if (rcnt_reg == 3'd4) begin
                        state_reg <= ST_CALC;
                        out_reg   <= '0;
                        t_reg     <= '0;
                    end else begin
                        rcnt_reg <= rcnt_reg + 3'd1;
                    end
                end
                ST_CALC: begin
                    t_reg <= t_reg + 2'd1;
                    if (t_reg == 2'd3) begin
                        out_reg <= out_reg + 2'd1;
                        if (out_reg == 2'd3) state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    state_reg <= ST_SETUP;
                    case (phase_reg)
                        PH_SWAP: begin
                            if (cnt_reg == LOGN'(HALF - 1)) begin
                                phase_reg <= PH_BFLY;
                                cnt_reg   <= '0;
                                stg_reg   <= '0;
                            end else begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end
                        PH_BFLY: begin
                            if (&cnt_reg[LOGN-2:0]) begin
                                cnt_reg <= '0;
                                if (stg_reg == STG_W'(LOGN - 1)) begin
                                    phase_reg <= PH_SPLIT;
                                    cnt_reg   <= LOGN'(1);
                                end else begin
                                    stg_reg <= stg_reg + 1'b1;
                                end
                            end else begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end
                        PH_SPLIT: begin
                            if (cnt_reg == LOGN'(QTR - 1)) begin
                                phase_reg <= PH_DC;
                            end else begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end
                        default: begin
                            state_reg <= ST_FIN;
                        end
                    endcase
                end
                ST_FIN: begin
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = (state_reg != ST_IDLE);
    assign done    = (state_reg == ST_FIN);

endmodule

`default_nettype wire

FILE: sv/real_fft_in_place.sv
// ----------------------------------------------------------------------------
// real_fft_in_place
// in-place packed real fft over a 512-word sample buffer
// ----------------------------------------------------------------------------
//  channel   dir   tdata                          tuser
//  s_        in    index[8:0], sample[24:9]       mode[1:0]
//  m_        out   read_value[15:0]               transform_done[0]
//
//  load and unused-mode items set the output register directly; a read first
//  passes a pending stage (one memory read with registered data)
//  a transform runs the bit-reversal sweep (an index left in place is only set
//  up and advanced, a swapped pair takes a full step), 8 stages of 128
//  butterflies, 127 split steps and the dc/nyquist step; a full step is setup,
//  four reads, four outputs each accumulated in the mac, and advance
//  aresetn is synchronous; the buffer is not cleared
//  a waiting result in the output register stalls the next item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "real_fft_in_place_macros.svh"

module real_fft_in_place (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // index[8:0], sample[24:9], zero pad
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // read_value[15:0]
    output logic [0:0]       m_tuser    // transform_done[0]
);
    import rfft_pkg::*;

    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    logic        m_done_reg;
    logic        pend_reg;
    logic        pend_ok_reg;
    logic        accept;
    logic        core_busy;
    logic        core_done;
    logic [15:0] core_rd;
    cmd_t        cmd;
    mode_t       in_mode;

    assign in_mode = mode_t'(s_tuser);

    // one item in flight; the output slot must be empty or emptying
    assign s_tready = !core_busy && !pend_reg && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd.valid   = accept;
        cmd.mode    = in_mode;
        cmd.addr    = ADDR_W'(s_tdata[8:0]);
        cmd.addr_ok = (32'(s_tdata[8:0]) < 32'(POINTS));
        cmd.sample  = s_tdata[24:9];
    end

    rfft_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rd_data (core_rd),
        .busy    (core_busy),
        .done    (core_done)
    );

    // output slot control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            pend_reg <= 1'b0;
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                case (in_mode)
                    MODE_READ: pend_reg <= 1'b1;
                    MODE_RUN:  ;
                    default:   m_valid_reg <= 1'b1;
                endcase
            end
            if (pend_reg || core_done) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_ok_reg <= cmd.addr_ok;
            m_data_reg  <= '0;
            m_done_reg  <= 1'b0;
        end
        if (pend_reg) begin
            m_data_reg <= pend_ok_reg ? core_rd : 16'd0;
            m_done_reg <= 1'b0;
        end
        if (core_done) begin
            m_data_reg <= '0;
            m_done_reg <= 1'b1;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_done_reg;

    // read data lands only in an empty slot
    `RFFT_ASSERT(a_pend_slot_free, aclk, aresetn, pend_reg, !m_valid_reg, "read result overwrites slot")
    // a finished transform finds the slot empty
    `RFFT_ASSERT(a_done_slot_free, aclk, aresetn, core_done, !m_valid_reg, "transform result overwrites slot")
    // a run item starts the sequencer
    `RFFT_ASSERT_NEXT(a_run_starts, aclk, aresetn, accept && (in_mode == MODE_RUN), core_busy, "run item did not start")

endmodule

`default_nettype wire

FILE: tb/real_fft_in_place_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// real_fft_in_place_tb
// self-checking bench for the in-place packed real fft: loads, reads, unused
// mode items and full transforms are checked against a bench-side fixed-point
// model of the buffer, with random gaps on the input and stalls on the output
// ----------------------------------------------------------------------------
module real_fft_in_place_tb;
    import rfft_pkg::*;

    localparam int               NWORDS     = 512;
    localparam logic [1:0]       MODE_SPARE = 2'd3;
    localparam longint unsigned  ANGLE_Q30  = 64'd6746518852;
    localparam int               IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [15:0] read_value;
        logic        transform_done;
    } fft_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    // bench copy of the sample buffer and the quarter-wave sine table
    logic signed [15:0] buf_model [NWORDS];
    longint             sine_q15 [NWORDS/4 + 1];

    fft_result_t result_q[$];
    int          errors;
    int          idle_cycles;
    int          n_loads, n_reads, n_runs, n_spare, n_results;
    bit          gaps_on;

    real_fft_in_place dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return v[15:0];
    endfunction

    // q2.30 taylor series of sin, rounded half up to q1.15
    function automatic longint sine_entry(input int j);
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        longint          r;
        x = (ANGLE_Q30 * 64'(j) + 64'(NWORDS / 2)) / 64'(NWORDS);
        acc = longint'(x);
        term = x;
        for (int k = 1; k <= 12; k++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        r = (acc + 16384) / 32768;
        if (r > 32767) r = 32767;
        return r;
    endfunction

    function automatic void angle_cs(input int idx, output longint c, output longint s);
        int q;
        q = NWORDS / 4;
        idx = idx % (NWORDS / 2);
        if (idx <= q) begin
            s = sine_q15[idx];
            c = sine_q15[q - idx];
        end else begin
            s = sine_q15[NWORDS/2 - idx];
            c = -sine_q15[idx - q];
        end
    endfunction

    // bit reversal, radix-2 complex stages, then the split into the real spectrum and the dc/nyquist step
    function automatic void fft_in_place();
        int                 n;
        int                 r;
        int                 a, b, i1, i2, i3, i4;
        longint             c, s, dr, di, ar, ai, tr, ti;
        longint             h1r, h1i, h2r, h2i, d0, d1;
        logic signed [15:0] t0, t1;
        n = NWORDS / 2;
        for (int i = 0; i < n; i++) begin
            r = 0;
            for (int bit_i = 0; bit_i < 8; bit_i++)
                if (i[bit_i]) r |= 1 << (7 - bit_i);
            if (r > i) begin
                t0 = buf_model[2*i];
                t1 = buf_model[2*i+1];
                buf_model[2*i]   = buf_model[2*r];
                buf_model[2*i+1] = buf_model[2*r+1];
                buf_model[2*r]   = t0;
                buf_model[2*r+1] = t1;
            end
        end
        for (int h = 1; h < n; h *= 2) begin
            for (int k = 0; k < h; k++) begin
                angle_cs(k * (NWORDS / (2 * h)), c, s);
                for (int g = k; g + h < n; g += 2 * h) begin
                    a  = 2 * g;
                    b  = 2 * (g + h);
                    dr = buf_model[b];
                    di = buf_model[b+1];
                    ar = longint'(buf_model[a]) * 32768;
                    ai = longint'(buf_model[a+1]) * 32768;
                    tr = c * dr - s * di;
                    ti = c * di + s * dr;
                    buf_model[b]   = clamp16((ar - tr) / 32768);
                    buf_model[b+1] = clamp16((ai - ti) / 32768);
                    buf_model[a]   = clamp16((ar + tr) / 32768);
                    buf_model[a+1] = clamp16((ai + ti) / 32768);
                end
            end
        end
        for (int i = 1; i < NWORDS / 4; i++) begin
            i1  = 2 * i;
            i2  = i1 + 1;
            i3  = NWORDS - i1;
            i4  = i3 + 1;
            h1r = (longint'(buf_model[i1]) + buf_model[i3]) * 32768;
            h1i = (longint'(buf_model[i2]) - buf_model[i4]) * 32768;
            h2r = longint'(buf_model[i2]) + buf_model[i4];
            h2i = longint'(buf_model[i3]) - buf_model[i1];
            angle_cs(i, c, s);
            buf_model[i1] = clamp16((h1r + c * h2r - s * h2i) / 65536);
            buf_model[i2] = clamp16((h1i + c * h2i + s * h2r) / 65536);
            buf_model[i3] = clamp16((h1r - c * h2r + s * h2i) / 65536);
            buf_model[i4] = clamp16((-h1i + c * h2i + s * h2r) / 65536);
        end
        d0 = buf_model[0];
        d1 = buf_model[1];
        buf_model[0] = clamp16(d0 + d1);
        buf_model[1] = clamp16(d0 - d1);
    endfunction

    // update the buffer copy for one accepted item and queue its result
    function automatic void predict_item(input logic [1:0] mode, input logic [8:0] idx,
                                         input logic [15:0] smp);
        fft_result_t res;
        res = '0;
        case (mode)
            MODE_LOAD: begin
                buf_model[idx] = smp;
                n_loads++;
            end
            MODE_RUN: begin
                fft_in_place();
                res.transform_done = 1'b1;
                n_runs++;
            end
            MODE_READ: begin
                res.read_value = buf_model[idx];
                n_reads++;
            end
            default: n_spare++;
        endcase
        result_q.push_back(res);
    endfunction

    // offer one item, with random gaps ahead of it while gaps_on is set, and wait for the handshake
    task automatic send_item(input logic [1:0] mode, input logic [8:0] idx,
                             input logic [15:0] smp);
        while (gaps_on && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'd0, smp, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(mode, idx, smp);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // output side: random stalls, result checking and the idle watchdog
    always @(posedge aclk) begin
        fft_result_t want;
        if (aresetn) begin
            m_tready <= (gaps_on && $urandom_range(99) < 22) ? 1'b0 : 1'b1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (m_tvalid && m_tready) begin
                n_results++;
                if (result_q.size() == 0) begin
                    $display("%0t: result with nothing pending: value %h done %b",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (m_tdata !== want.read_value) begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.read_value, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== want.transform_done) begin
                        $display("%0t: transform_done expected %b actual %b",
                                 $time, want.transform_done, m_tuser[0]);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // extremes across the buffer, read back, unused mode, a pause, then load-read pairs
    task automatic test_directed();
        send_item(MODE_LOAD, 9'd0,   16'h7fff);
        send_item(MODE_LOAD, 9'd511, 16'h8000);
        send_item(MODE_LOAD, 9'd256, 16'hffff);
        send_item(MODE_LOAD, 9'd1,   16'h0000);
        send_item(MODE_LOAD, 9'd170, 16'h5555);
        send_item(MODE_LOAD, 9'd341, 16'haaaa);
        send_item(MODE_READ, 9'd0,   16'hffff);
        send_item(MODE_READ, 9'd511, 16'h0000);
        send_item(MODE_READ, 9'd256, 16'h1234);
        send_item(MODE_READ, 9'd1,   16'h0000);
        send_item(MODE_READ, 9'd170, 16'h0000);
        send_item(MODE_READ, 9'd341, 16'h0000);
        // unused mode does nothing, even with a load-like payload
        send_item(MODE_SPARE, 9'd0,   16'h0001);
        send_item(MODE_SPARE, 9'd511, 16'hffff);
        send_item(MODE_READ,  9'd0,   16'h0000);
        drain_results();
        // load then read of the same word, twice with different values
        send_item(MODE_LOAD, 9'd2, 16'h0102);
        send_item(MODE_READ, 9'd2, 16'h0000);
        send_item(MODE_LOAD, 9'd2, 16'hfedc);
        send_item(MODE_READ, 9'd2, 16'h0000);
    endtask

    // fill the whole buffer, transform, read some bins
    task automatic test_transform(input int fill_kind);
        logic [15:0] v;
        for (int i = 0; i < NWORDS; i++) begin
            case (fill_kind)
                0: v = pick_sample();
                1: v = 16'h8000;   // full-scale dc drives the butterfly stages into saturation
                default: v = (i % 2 == 0) ? 16'h7fff : 16'h8000;
            endcase
            send_item(MODE_LOAD, 9'(i), v);
        end
        send_item(MODE_RUN, 9'($urandom), 16'($urandom));
        for (int i = 0; i < 8; i++) send_item(MODE_READ, 9'(i), 16'($urandom));
        send_item(MODE_READ, 9'd256, 16'($urandom));
        send_item(MODE_READ, 9'd511, 16'($urandom));
    endtask

    // mixed traffic on a fully written buffer, with the odd transform
    task automatic test_random(input int count);
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (i % 260 == 259) send_item(MODE_RUN, 9'($urandom), 16'($urandom));
            else if (roll < 46) send_item(MODE_LOAD, 9'($urandom), pick_sample());
            else if (roll < 96) send_item(MODE_READ, 9'($urandom), 16'($urandom));
            else send_item(MODE_SPARE, 9'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_LOAD;
        m_tready = 1'b0;
        gaps_on  = 1'b1;
        errors = 0;
        idle_cycles = 0;
        n_loads = 0;
        n_reads = 0;
        n_runs = 0;
        n_spare = 0;
        n_results = 0;
        for (int j = 0; j <= NWORDS / 4; j++) sine_q15[j] = sine_entry(j);
        for (int j = 0; j < NWORDS; j++) begin
            buf_model[j] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        // no gaps and no stalls through the first fill
        gaps_on = 1'b0;
        test_transform(0);
        gaps_on = 1'b1;
        test_transform(1);
        test_transform(2);
        test_random(262);

        drain_results();
        repeat (60) @(posedge aclk);
        $display("covered %0d loads, %0d reads, %0d transforms, %0d unused-mode items",
                 n_loads, n_reads, n_runs, n_spare);
        $display("%0d results checked, %0d mismatches", n_results, errors);
        if (errors == 0 && result_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
